FILE: sv/spa_pkg.sv
// spa_pkg: types, codes and constants shared by the sprite pixel access unit
// used by spa_decode, spa_pixel and sprite_pixel_access_unit; depends on nothing

package spa_pkg;

  localparam int STORE_BYTES = 64;
  localparam int SPRITE_ROWS = 21;
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_PAINT = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_COLOR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FORE_COLOR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MULTI_ONE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MULTI_TWO = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PAINT_INDEX = 3'd5;

  localparam logic [4:0] MONO_WIDTH = 5'd24;
  localparam logic [4:0] MULTI_WIDTH = 5'd12;
  localparam logic [4:0] SIXTEEN_WIDTH = 5'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [4:0] x_pos;
    logic [4:0] y_pos;
    logic [5:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pixel_color;
    logic       opaque;
    logic [3:0] pixel_code;
    logic       range_error;
  } out_item_t;

  typedef struct packed {
    logic [1:0] color_mode;
    logic [3:0] back_color;
    logic [3:0] fore_color;
    logic [3:0] multi_one_color;
    logic [3:0] multi_two_color;
    logic [1:0] paint_index;
  } cfg_t;

  // decoded access held between the input register and the result register
  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        sub;
    logic              range_err;
    logic [7:0]        byte_value;
  } access_t;

endpackage

FILE: sv/spa_ram.sv
// spa_ram: generic single write port ram with one registered read port
// depends on nothing

module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/spa_decode.sv
// spa_decode: turns an input item into a store address, pixel position and range flag
// depends on spa_pkg

module spa_decode #(
  parameter int SPRITE_ROWS = spa_pkg::SPRITE_ROWS
) (
  input  spa_pkg::in_item_t item,
  input  logic [1:0]        color_mode,
  output spa_pkg::access_t  acc
);

  logic [6:0] row_base;
  logic [6:0] col;
  logic [6:0] sum;
  logic [4:0] width;
  logic [2:0] sub;
  logic       bad;

  always_comb begin
    row_base = ({2'b00, item.y_pos} << 1) + {2'b00, item.y_pos};
    if (color_mode[1]) begin
      // sixteen-colour, also taken for the unused mode
      col = {3'b000, item.x_pos[4:1]};
      sub = {2'b00, item.x_pos[0]};
      width = spa_pkg::SIXTEEN_WIDTH;
    end else if (color_mode[0]) begin
      col = {4'b0000, item.x_pos[4:2]};
      sub = {1'b0, item.x_pos[1:0]};
      width = spa_pkg::MULTI_WIDTH;
    end else begin
      col = {5'b00000, item.x_pos[4:3]};
      sub = item.x_pos[2:0];
      width = spa_pkg::MONO_WIDTH;
    end
    sum = row_base + col;
    bad = (item.x_pos >= width) || (item.y_pos >= 5'(SPRITE_ROWS));

    acc.opcode = item.opcode;
    acc.sub = sub;
    acc.byte_value = item.byte_value;
    if (item.opcode == spa_pkg::OP_LOAD) begin
      acc.addr = item.byte_index[spa_pkg::ADDR_W-1:0];
      acc.range_err = 1'b0;
    end else begin
      acc.addr = sum[spa_pkg::ADDR_W-1:0];
      acc.range_err = bad;
    end
  end

endmodule

FILE: sv/spa_pixel.sv
// spa_pixel: pixel extract, paint merge and palette lookup on one store byte
// depends on spa_pkg

module spa_pixel (
  input  spa_pkg::access_t   acc,
  input  spa_pkg::cfg_t      cfg,
  input  logic [7:0]         old_byte,
  output logic               write_req,
  output logic [7:0]         new_byte,
  output spa_pkg::out_item_t result
);

  logic [2:0] sh;
  logic [7:0] mask;
  logic [3:0] paint;
  logic [3:0] slot_color;
  logic [7:0] merged;
  logic [7:0] field;
  logic [3:0] code;
  logic [3:0] color;
  logic       paint_op;

  always_comb begin
    case (cfg.paint_index)
      2'd0:    slot_color = cfg.back_color;
      2'd1:    slot_color = cfg.fore_color;
      2'd2:    slot_color = cfg.multi_one_color;
      default: slot_color = cfg.multi_two_color;
    endcase

    if (cfg.color_mode[1]) begin
      sh = acc.sub[0] ? 3'd0 : 3'd4;
      mask = 8'h0F << sh;
      paint = slot_color;
    end else if (cfg.color_mode[0]) begin
      sh = 3'd6 - {acc.sub[1:0], 1'b0};
      mask = 8'h03 << sh;
      // back, fore, mc1, mc2 map to codes 00, 10, 01, 11
      paint = {2'b00, cfg.paint_index[0], cfg.paint_index[1]};
    end else begin
      sh = 3'd7 - acc.sub;
      mask = 8'h01 << sh;
      paint = {3'b000, (cfg.paint_index != 2'd0)};
    end

    paint_op = (acc.opcode == spa_pkg::OP_PAINT) && !acc.range_err;
    merged = (old_byte & ~mask) | (({4'b0000, paint} << sh) & mask);

    if (acc.opcode == spa_pkg::OP_LOAD) begin
      write_req = 1'b1;
      new_byte = acc.byte_value;
    end else begin
      write_req = paint_op;
      new_byte = paint_op ? merged : old_byte;
    end

    field = (paint_op ? merged : old_byte) >> sh;
    if (cfg.color_mode[1]) begin
      code = field[3:0];
      color = field[3:0];
    end else if (cfg.color_mode[0]) begin
      code = {2'b00, field[1:0]};
      case (field[1:0])
        2'd0:    color = cfg.back_color;
        2'd1:    color = cfg.multi_one_color;
        2'd2:    color = cfg.fore_color;
        default: color = cfg.multi_two_color;
      endcase
    end else begin
      code = {3'b000, field[0]};
      color = field[0] ? cfg.fore_color : cfg.back_color;
    end

    if (acc.opcode == spa_pkg::OP_LOAD || acc.range_err) begin
      result.pixel_color = 4'd0;
      result.opaque = 1'b0;
      result.pixel_code = 4'd0;
      result.range_error = acc.range_err;
    end else begin
      result.pixel_color = color;
      result.opaque = (code != 4'd0);
      result.pixel_code = code;
      result.range_error = 1'b0;
    end
  end

endmodule

FILE: sv/sprite_pixel_access_unit.sv
// sprite_pixel_access_unit: top level with configuration registers, pipeline control
// depends on spa_pkg, spa_ram, spa_decode and spa_pixel
//
// Usage:
//   in channel (in_valid, in_stall, in_item) carries one operation per item:
//   read pixel, paint pixel or load raw byte. out channel (out_valid, out_stall,
//   out_item) returns exactly one result item per input item, in order.
//   An item is taken in the edge where valid is high and stall is low.
//   The item waits in the input register and its result in the output register.
//   One item per cycle while the output is not stalled; the store read-modify-write
//   happens in the stage behind the input register, with the last write forwarded
//   so that back-to-back items on the same byte see each other.
//   Configuration: cfg_write with cfg_index and cfg_data, one register per edge;
//   write only while no item is in flight, which the block does not enforce.
//   Reset (rst, synchronous): pipeline emptied and colour registers set to their
//   defaults; the sprite store is not cleared and must be loaded before reading.
//   A stalled output holds its item; the stage behind it then holds too and
//   in_stall rises until the receiver takes the result.

module sprite_pixel_access_unit #(
  parameter int SPRITE_ROWS = spa_pkg::SPRITE_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [spa_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spa_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output spa_pkg::out_item_t                  out_item
);

  spa_pkg::cfg_t      cfg;
  spa_pkg::access_t   dec_acc;
  spa_pkg::access_t   s1_acc;
  logic               s1_valid;
  logic               accept;
  logic               advance;
  logic [spa_pkg::ADDR_W-1:0] raddr;
  logic [7:0]         rdata;
  logic [7:0]         cur_byte;
  logic               byp_valid;
  logic [spa_pkg::ADDR_W-1:0] byp_addr;
  logic [7:0]         byp_data;
  logic               write_req;
  logic               we;
  logic [7:0]         new_byte;
  spa_pkg::out_item_t result;

  assign advance = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept = in_valid && !in_stall;
  assign raddr = in_stall ? s1_acc.addr : dec_acc.addr;
  assign cur_byte = (byp_valid && byp_addr == s1_acc.addr) ? byp_data : rdata;
  assign we = advance && write_req;

  spa_decode #(
    .SPRITE_ROWS(SPRITE_ROWS)
  ) u_decode (
    .item      (in_item),
    .color_mode(cfg.color_mode),
    .acc       (dec_acc)
  );

  spa_ram #(
    .WIDTH(8),
    .DEPTH(spa_pkg::STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(s1_acc.addr),
    .wdata(new_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  spa_pixel u_pixel (
    .acc      (s1_acc),
    .cfg      (cfg),
    .old_byte (cur_byte),
    .write_req(write_req),
    .new_byte (new_byte),
    .result   (result)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_mode <= 2'd0;
      cfg.back_color <= 4'd11;
      cfg.fore_color <= 4'd1;
      cfg.multi_one_color <= 4'd3;
      cfg.multi_two_color <= 4'd4;
      cfg.paint_index <= 2'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        spa_pkg::REG_COLOR_MODE:  cfg.color_mode <= cfg_data[1:0];
        spa_pkg::REG_BACK_COLOR:  cfg.back_color <= cfg_data;
        spa_pkg::REG_FORE_COLOR:  cfg.fore_color <= cfg_data;
        spa_pkg::REG_MULTI_ONE:   cfg.multi_one_color <= cfg_data;
        spa_pkg::REG_MULTI_TWO:   cfg.multi_two_color <= cfg_data;
        spa_pkg::REG_PAINT_INDEX: cfg.paint_index <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // pipeline control and last-write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      byp_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !advance);
      byp_valid <= we;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_acc <= dec_acc;
    end
    if (we) begin
      byp_addr <= s1_acc.addr;
      byp_data <= new_byte;
    end
    if (advance) begin
      out_item <= result;
    end
  end

endmodule
